[rtl/cgh_pkg.sv]
// Shared types and constants of the coincidence gate histogrammer.
`timescale 1ns / 1ps
package cgh_pkg;

  localparam int EW = 23;
  typedef logic signed [EW-1:0] energy_t;

  localparam int E_MAX_INT = 4194303;
  localparam logic signed [EW-1:0] SCAT_MIN = 23'sd320;  // 20 keV
  localparam logic signed [EW-1:0] DET_MIN  = 23'sd160;  // 10 keV
  localparam int W_SINGLE = 160;
  localparam int W_SUM    = 192;
  localparam int W_PAIR   = 128;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [2:0] HIST_TAG  = 3'd0;
  localparam logic [2:0] HIST_DET  = 3'd1;
  localparam logic [2:0] HIST_SCAT = 3'd2;
  localparam logic [2:0] HIST_SUM  = 3'd3;
  localparam logic [2:0] HIST_PAIR = 3'd4;

  localparam logic [2:0] REG_TAG_OFFSET  = 3'd0;
  localparam logic [2:0] REG_TAG_GAIN    = 3'd1;
  localparam logic [2:0] REG_SCAT_OFFSET = 3'd2;
  localparam logic [2:0] REG_SCAT_GAIN   = 3'd3;
  localparam logic [2:0] REG_DET_OFFSET  = 3'd4;
  localparam logic [2:0] REG_DET_GAIN    = 3'd5;
  localparam logic [2:0] REG_WIN_LOW     = 3'd6;
  localparam logic [2:0] REG_WIN_HIGH    = 3'd7;

  typedef struct packed {
    logic        accepted;
    logic [31:0] total;
    energy_t     tag_energy;
    energy_t     scat_energy;
    energy_t     det_energy;
    logic [31:0] count;
  } result_t;

endpackage

[rtl/coincidence_gate_histogrammer.sv]
// Pipeline: products, cuts and bins, memory requests, result, then the output queue.
// Throughput: one item per cycle while in_ready_o is high; each histogram memory does
// one read and one write per cycle, back-to-back updates of one bin are forwarded.
// Reset: configuration takes its defaults and counts clear at once; then a
// clearing pass zeroes every bin of the memories, and no input is taken meanwhile.
// Output queue of 8 entries absorbs in-flight items while out_ready_i is low.
`timescale 1ns / 1ps
module coincidence_gate_histogrammer #(
  parameter int NUM_BINS = 100,
  parameter int ADC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [ADC_BITS-1:0]   tag_raw_i,
  input  logic [ADC_BITS-1:0]   scat_raw_i,
  input  logic [ADC_BITS-1:0]   det_raw_i,
  input  logic [2:0]            hist_select_i,
  input  logic [6:0]            bin_x_i,
  input  logic [6:0]            bin_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  accepted_o,
  output logic [31:0]           accepted_total_o,
  output logic signed [22:0]    tag_energy_o,
  output logic signed [22:0]    scat_energy_o,
  output logic signed [22:0]    det_energy_o,
  output logic [31:0]           bin_count_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int BW   = $clog2(NUM_BINS);
  localparam int N2   = NUM_BINS * NUM_BINS;
  localparam int PAW  = $clog2(N2);
  localparam int CW   = $clog2(N2 + 1);
  localparam int FD   = 8;
  localparam int FAW  = 3;
  localparam int IW   = 4;
  localparam int LIM_S   = NUM_BINS * cgh_pkg::W_SINGLE;
  localparam int LIM_SUM = NUM_BINS * cgh_pkg::W_SUM;
  localparam int LIM_P   = NUM_BINS * cgh_pkg::W_PAIR;
  localparam int XS_W = $clog2(NUM_BINS * 5);
  localparam int YS_W = $clog2(NUM_BINS * 3);

  // ---------------- configuration ----------------
  logic signed [14:0] tag_off_q, scat_off_q, det_off_q;
  logic [15:0]        tag_gain_q, scat_gain_q, det_gain_q, win_lo_q, win_hi_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_off_q   <= -15'sd216;
      tag_gain_q  <= 16'd9630;
      scat_off_q  <= -15'sd228;
      scat_gain_q <= 16'd11705;
      det_off_q   <= -15'sd177;
      det_gain_q  <= 16'd9883;
      win_lo_q    <= 16'd7520;
      win_hi_q    <= 16'd8480;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        cgh_pkg::REG_TAG_OFFSET:  tag_off_q   <= pwdata[14:0];
        cgh_pkg::REG_TAG_GAIN:    tag_gain_q  <= pwdata[15:0];
        cgh_pkg::REG_SCAT_OFFSET: scat_off_q  <= pwdata[14:0];
        cgh_pkg::REG_SCAT_GAIN:   scat_gain_q <= pwdata[15:0];
        cgh_pkg::REG_DET_OFFSET:  det_off_q   <= pwdata[14:0];
        cgh_pkg::REG_DET_GAIN:    det_gain_q  <= pwdata[15:0];
        cgh_pkg::REG_WIN_LOW:     win_lo_q    <= pwdata[15:0];
        cgh_pkg::REG_WIN_HIGH:    win_hi_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      cgh_pkg::REG_TAG_OFFSET:  prdata = 32'(tag_off_q);
      cgh_pkg::REG_TAG_GAIN:    prdata = 32'(tag_gain_q);
      cgh_pkg::REG_SCAT_OFFSET: prdata = 32'(scat_off_q);
      cgh_pkg::REG_SCAT_GAIN:   prdata = 32'(scat_gain_q);
      cgh_pkg::REG_DET_OFFSET:  prdata = 32'(det_off_q);
      cgh_pkg::REG_DET_GAIN:    prdata = 32'(det_gain_q);
      cgh_pkg::REG_WIN_LOW:     prdata = 32'(win_lo_q);
      cgh_pkg::REG_WIN_HIGH:    prdata = 32'(win_hi_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- bin helpers ----------------
  function automatic logic [BW:0] bin_single(logic signed [22:0] e);
    logic [XS_W-1:0]    x;
    logic [XS_W+15:0]   m;
    logic               ok;
    ok = !e[22] && (e < 23'(LIM_S));
    x  = XS_W'(e[22:5]);
    // divide by 5 through the reciprocal
    m  = (XS_W+16)'(x) * (XS_W+16)'(16'd52429);
    return {ok, BW'(m >> 18)};
  endfunction

  function automatic logic [BW:0] bin_sum(logic signed [23:0] s);
    logic [YS_W-1:0]    y;
    logic [YS_W+15:0]   m;
    logic               ok;
    ok = !s[23] && (s < 24'(LIM_SUM));
    y  = YS_W'(s[23:6]);
    m  = (YS_W+16)'(y) * (YS_W+16)'(16'd43691);
    return {ok, BW'(m >> 17)};
  endfunction

  function automatic logic [BW:0] bin_pair(logic signed [22:0] e);
    logic ok;
    ok = !e[22] && (e < 23'(LIM_P));
    return {ok, BW'(e[22:7])};
  endfunction

  // ---------------- control ----------------
  logic            in_acc, pop;
  logic            clearing_q;
  logic [CW-1:0]   clr_cnt_q;
  logic [IW-1:0]   inflight_q;
  logic [IW-1:0]   fcnt_q;
  logic [FAW-1:0]  wp_q, rp_q;

  assign in_ready_o  = !clearing_q && (inflight_q < IW'(FD));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (fcnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  // ---------------- stage 1: products ----------------
  logic       v1_q, cmd1_q;
  logic [2:0] sel1_q;
  logic [6:0] x1_q, y1_q;
  cgh_pkg::energy_t et, es, ed;

  cgh_calib #(.ADC_BITS(ADC_BITS)) u_tag (
    .clk_i(clk_i), .en_i(in_acc), .raw_i(tag_raw_i), .gain_i(tag_gain_q),
    .offset_i(tag_off_q), .energy_o(et));
  cgh_calib #(.ADC_BITS(ADC_BITS)) u_scat (
    .clk_i(clk_i), .en_i(in_acc), .raw_i(scat_raw_i), .gain_i(scat_gain_q),
    .offset_i(scat_off_q), .energy_o(es));
  cgh_calib #(.ADC_BITS(ADC_BITS)) u_det (
    .clk_i(clk_i), .en_i(in_acc), .raw_i(det_raw_i), .gain_i(det_gain_q),
    .offset_i(det_off_q), .energy_o(ed));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd1_q <= command_i;
      sel1_q <= hist_select_i;
      x1_q   <= bin_x_i;
      y1_q   <= bin_y_i;
    end
  end

  // ---------------- stage 2: cuts and bins ----------------
  logic       v2_q, cmd2_q;
  logic [2:0] sel2_q;
  logic [6:0] x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    cmd2_q <= cmd1_q;
    sel2_q <= sel1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
  end

  logic              is_event, acc2, rd_ok2;
  logic [BW:0]       tb, db, sb, smb, pdb, psb;
  logic signed [23:0] esum;
  logic [31:0]       cnt_q, cnt_d;
  logic [PAW-1:0]    pair_ev, pair_rd;

  assign is_event = (cmd2_q == cgh_pkg::CMD_EVENT);
  assign acc2 = is_event
             && (et > $signed({7'd0, win_lo_q})) && (et < $signed({7'd0, win_hi_q}))
             && (es > cgh_pkg::SCAT_MIN) && (ed > cgh_pkg::DET_MIN);
  assign esum = 24'(ed) + 24'(es);
  assign tb   = bin_single(et);
  assign db   = bin_single(ed);
  assign sb   = bin_single(es);
  assign smb  = bin_sum(esum);
  assign pdb  = bin_pair(ed);
  assign psb  = bin_pair(es);
  assign pair_ev = PAW'(pdb[BW-1:0]) * PAW'(NUM_BINS) + PAW'(psb[BW-1:0]);
  assign pair_rd = PAW'(x2_q) * PAW'(NUM_BINS) + PAW'(y2_q);
  assign rd_ok2  = !is_event && (32'(x2_q) < NUM_BINS)
                && ((sel2_q == cgh_pkg::HIST_TAG) || (sel2_q == cgh_pkg::HIST_DET)
                 || (sel2_q == cgh_pkg::HIST_SCAT) || (sel2_q == cgh_pkg::HIST_SUM)
                 || ((sel2_q == cgh_pkg::HIST_PAIR) && (32'(y2_q) < NUM_BINS)));
  assign cnt_d = (v2_q && acc2 && cnt_q != cgh_pkg::CNT_MAX) ? cnt_q + 32'd1 : cnt_q;

  // ---------------- stage 3: memory requests ----------------
  logic             v3_q, acc3_q, rd_ok3_q;
  logic [2:0]       sel3_q;
  logic [31:0]      total3_q;
  cgh_pkg::energy_t et3_q, es3_q, ed3_q;
  logic [BW-1:0]    a_tag_q, a_det_q, a_scat_q, a_sum_q;
  logic [PAW-1:0]   a_pair_q;
  logic             i_tag_q, i_det_q, i_scat_q, i_sum_q, i_pair_q;

  always_ff @(posedge clk_i) begin
    acc3_q   <= acc2;
    rd_ok3_q <= rd_ok2;
    sel3_q   <= sel2_q;
    total3_q <= cnt_d;
    et3_q    <= is_event ? et : '0;
    es3_q    <= is_event ? es : '0;
    ed3_q    <= is_event ? ed : '0;
    a_tag_q  <= is_event ? tb[BW-1:0]  : BW'(x2_q);
    a_det_q  <= is_event ? db[BW-1:0]  : BW'(x2_q);
    a_scat_q <= is_event ? sb[BW-1:0]  : BW'(x2_q);
    a_sum_q  <= is_event ? smb[BW-1:0] : BW'(x2_q);
    a_pair_q <= is_event ? pair_ev : pair_rd;
    i_tag_q  <= is_event && tb[BW];
    i_det_q  <= acc2 && db[BW];
    i_scat_q <= acc2 && sb[BW];
    i_sum_q  <= acc2 && smb[BW];
    i_pair_q <= acc2 && pdb[BW] && psb[BW];
  end

  // ---------------- histogram banks ----------------
  logic          clr_small;
  logic [31:0]   c_tag, c_det, c_scat, c_sum, c_pair;

  assign clr_small = clearing_q && (32'(clr_cnt_q) < NUM_BINS);

  cgh_hist_bank #(.DEPTH(NUM_BINS), .AW(BW)) u_tag_hist (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(v3_q), .inc_i(i_tag_q), .addr_i(a_tag_q),
    .clr_i(clr_small), .clr_addr_i(BW'(clr_cnt_q)), .count_o(c_tag));
  cgh_hist_bank #(.DEPTH(NUM_BINS), .AW(BW)) u_det_hist (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(v3_q), .inc_i(i_det_q), .addr_i(a_det_q),
    .clr_i(clr_small), .clr_addr_i(BW'(clr_cnt_q)), .count_o(c_det));
  cgh_hist_bank #(.DEPTH(NUM_BINS), .AW(BW)) u_scat_hist (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(v3_q), .inc_i(i_scat_q), .addr_i(a_scat_q),
    .clr_i(clr_small), .clr_addr_i(BW'(clr_cnt_q)), .count_o(c_scat));
  cgh_hist_bank #(.DEPTH(NUM_BINS), .AW(BW)) u_sum_hist (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(v3_q), .inc_i(i_sum_q), .addr_i(a_sum_q),
    .clr_i(clr_small), .clr_addr_i(BW'(clr_cnt_q)), .count_o(c_sum));
  cgh_hist_bank #(.DEPTH(N2), .AW(PAW)) u_pair_hist (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(v3_q), .inc_i(i_pair_q), .addr_i(a_pair_q),
    .clr_i(clearing_q), .clr_addr_i(PAW'(clr_cnt_q)), .count_o(c_pair));

  // ---------------- stage 4: result ----------------
  logic             v4_q, acc4_q, rd_ok4_q;
  logic [2:0]       sel4_q;
  logic [31:0]      total4_q;
  cgh_pkg::energy_t et4_q, es4_q, ed4_q;
  logic [31:0]      bin_cnt;
  cgh_pkg::result_t res;

  always_ff @(posedge clk_i) begin
    acc4_q   <= acc3_q;
    rd_ok4_q <= rd_ok3_q;
    sel4_q   <= sel3_q;
    total4_q <= total3_q;
    et4_q    <= et3_q;
    es4_q    <= es3_q;
    ed4_q    <= ed3_q;
  end

  always_comb begin
    case (sel4_q)
      cgh_pkg::HIST_TAG:  bin_cnt = c_tag;
      cgh_pkg::HIST_DET:  bin_cnt = c_det;
      cgh_pkg::HIST_SCAT: bin_cnt = c_scat;
      cgh_pkg::HIST_SUM:  bin_cnt = c_sum;
      cgh_pkg::HIST_PAIR: bin_cnt = c_pair;
      default:            bin_cnt = '0;
    endcase
    res.accepted    = acc4_q;
    res.total       = total4_q;
    res.tag_energy  = et4_q;
    res.scat_energy = es4_q;
    res.det_energy  = ed4_q;
    res.count       = rd_ok4_q ? bin_cnt : '0;
  end

  // ---------------- output queue ----------------
  cgh_pkg::result_t fifo_q [FD];
  cgh_pkg::result_t head;

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      fifo_q[wp_q] <= res;
    end
  end

  assign head             = fifo_q[rp_q];
  assign accepted_o       = head.accepted;
  assign accepted_total_o = head.total;
  assign tag_energy_o     = head.tag_energy;
  assign scat_energy_o    = head.scat_energy;
  assign det_energy_o     = head.det_energy;
  assign bin_count_o      = head.count;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      cnt_q      <= '0;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      inflight_q <= '0;
      fcnt_q     <= '0;
      wp_q       <= '0;
      rp_q       <= '0;
    end else begin
      v1_q  <= in_acc;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      cnt_q <= cnt_d;
      if (clearing_q) begin
        if (clr_cnt_q == CW'(N2 - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + CW'(1);
      end
      inflight_q <= inflight_q + IW'(in_acc) - IW'(pop);
      fcnt_q     <= fcnt_q + IW'(v4_q) - IW'(pop);
      if (v4_q) begin
        wp_q <= wp_q + FAW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + FAW'(1);
      end
    end
  end

  // ---------------- assertions ----------------
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= IW'(FD))
    else $error("in-flight count above queue depth");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_queue_within_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= inflight_q)
    else $error("queue holds more than in flight");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !pop) |-> (fcnt_q < IW'(FD)))
    else $error("output queue overflow");

endmodule

[rtl/cgh_calib.sv]
// Two-stage linear calibration of one ADC channel.
`timescale 1ns / 1ps
module cgh_calib #(
  parameter int ADC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ADC_BITS-1:0]   raw_i,
  input  logic [15:0]           gain_i,
  input  logic signed [14:0]    offset_i,
  output cgh_pkg::energy_t      energy_o
);

  localparam int PW = 16 + ADC_BITS;
  localparam int RW = PW - 7;
  localparam int SW = (PW - 5 > 25) ? PW - 5 : 25;

  logic [PW-1:0]        prod_q;
  logic [RW-1:0]        rnd;
  logic signed [SW-1:0] sum;
  cgh_pkg::energy_t     energy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(gain_i) * PW'(raw_i);
    end
  end

  // round half up at bit 8
  assign rnd = RW'(({1'b0, prod_q} + (PW+1)'(128)) >> 8);
  assign sum = $signed(SW'(rnd)) + SW'(offset_i);

  always_ff @(posedge clk_i) begin
    if (sum > SW'(cgh_pkg::E_MAX_INT)) begin
      energy_q <= cgh_pkg::EW'(cgh_pkg::E_MAX_INT);
    end else begin
      energy_q <= sum[cgh_pkg::EW-1:0];
    end
  end

  assign energy_o = energy_q;

endmodule

[rtl/cgh_hist_bank.sv]
// Histogram memory with read-modify-write, write forwarding and clear port.
`timescale 1ns / 1ps
module cgh_hist_bank #(
  parameter int DEPTH = 100,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          inc_i,
  input  logic [AW-1:0] addr_i,
  input  logic          clr_i,
  input  logic [AW-1:0] clr_addr_i,
  output logic [31:0]   count_o
);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;
  logic [AW-1:0] addr_q;
  logic          inc_q;
  logic          en_q;
  logic [AW-1:0] wa_q;
  logic [31:0]   wd_q;
  logic          wv_q;
  logic [31:0]   count;
  logic [31:0]   wr_data;
  logic          wr_en;

  // the previous write lands in the same edge as this read; take it from wd_q
  assign count   = (wv_q && wa_q == addr_q) ? wd_q : rdata_q;
  assign wr_en   = en_q && inc_q;
  assign wr_data = (count == cgh_pkg::CNT_MAX) ? count : count + 32'd1;
  assign count_o = count;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
    if (clr_i) begin
      mem[clr_addr_i] <= '0;
    end else if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q <= addr_i;
      inc_q  <= inc_i;
    end
    if (wr_en) begin
      wa_q <= addr_q;
      wd_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      wv_q <= 1'b0;
    end else begin
      en_q <= en_i;
      if (clr_i) begin
        wv_q <= 1'b0;
      end else if (wr_en) begin
        wv_q <= 1'b1;
      end
    end
  end

endmodule

[sim/cgh_checker.sv]
// Result predictor and scoreboard for the coincidence gate histogrammer.
`timescale 1ns / 1ps
module cgh_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               command_i,
  input  logic [13:0]        tag_raw_i,
  input  logic [13:0]        scat_raw_i,
  input  logic [13:0]        det_raw_i,
  input  logic [2:0]         hist_select_i,
  input  logic [6:0]         bin_x_i,
  input  logic [6:0]         bin_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               accepted_i,
  input  logic [31:0]        accepted_total_i,
  input  logic signed [22:0] tag_energy_i,
  input  logic signed [22:0] scat_energy_i,
  input  logic signed [22:0] det_energy_i,
  input  logic [31:0]        bin_count_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int NB = 100;

  longint tag_off, scat_off, det_off;
  longint tag_gn, scat_gn, det_gn, win_lo, win_hi;
  logic [31:0] tag_h[NB], det_h[NB], scat_h[NB], sum_h[NB];
  logic [31:0] pair_h[NB*NB];
  logic [31:0] acc_cnt;
  cgh_pkg::result_t expected_q[$];

  function automatic longint calibrate(logic [13:0] raw, longint off, longint gn);
    longint e;
    e = off + ((gn * longint'(raw) + 128) >>> 8);
    return (e > cgh_pkg::E_MAX_INT) ? cgh_pkg::E_MAX_INT : e;
  endfunction

  function automatic int bin_index(longint e, int w);
    if (e < 0) return -1;
    return (e / w < NB) ? int'(e / w) : -1;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == cgh_pkg::CNT_MAX) ? c : c + 32'd1;
  endfunction

  task automatic predict_item();
    cgh_pkg::result_t r;
    longint et, es, ed;
    int b, by;
    r = '0;
    if (command_i == cgh_pkg::CMD_EVENT) begin
      et = calibrate(tag_raw_i, tag_off, tag_gn);
      es = calibrate(scat_raw_i, scat_off, scat_gn);
      ed = calibrate(det_raw_i, det_off, det_gn);
      b = bin_index(et, cgh_pkg::W_SINGLE);
      if (b >= 0) tag_h[b] = sat_inc(tag_h[b]);
      if (et > win_lo && et < win_hi && es > 320 && ed > 160) begin
        r.accepted = 1'b1;
        acc_cnt = sat_inc(acc_cnt);
        b = bin_index(ed, cgh_pkg::W_SINGLE);
        if (b >= 0) det_h[b] = sat_inc(det_h[b]);
        b = bin_index(es, cgh_pkg::W_SINGLE);
        if (b >= 0) scat_h[b] = sat_inc(scat_h[b]);
        b = bin_index(ed + es, cgh_pkg::W_SUM);
        if (b >= 0) sum_h[b] = sat_inc(sum_h[b]);
        b = bin_index(ed, cgh_pkg::W_PAIR);
        by = bin_index(es, cgh_pkg::W_PAIR);
        if (b >= 0 && by >= 0) pair_h[b*NB+by] = sat_inc(pair_h[b*NB+by]);
      end
      r.tag_energy = et[22:0];
      r.scat_energy = es[22:0];
      r.det_energy = ed[22:0];
    end else if (bin_x_i < NB) begin
      case (hist_select_i)
        cgh_pkg::HIST_TAG:  r.count = tag_h[bin_x_i];
        cgh_pkg::HIST_DET:  r.count = det_h[bin_x_i];
        cgh_pkg::HIST_SCAT: r.count = scat_h[bin_x_i];
        cgh_pkg::HIST_SUM:  r.count = sum_h[bin_x_i];
        cgh_pkg::HIST_PAIR: if (bin_y_i < NB) r.count = pair_h[bin_x_i*NB+bin_y_i];
        default: ;
      endcase
    end
    r.total = acc_cnt;
    expected_q.push_back(r);
  endtask

  task automatic compare_result();
    cgh_pkg::result_t e, a;
    a = '{accepted_i, accepted_total_i, tag_energy_i, scat_energy_i, det_energy_i,
          bin_count_i};
    if (expected_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected result %h", a);
      return;
    end
    e = expected_q.pop_front();
    if (a !== e) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display({"mismatch: exp acc=%0d tot=%0d te=%0d se=%0d de=%0d cnt=%0d",
                  " | got acc=%0d tot=%0d te=%0d se=%0d de=%0d cnt=%0d"},
                 e.accepted, e.total, e.tag_energy, e.scat_energy, e.det_energy, e.count,
                 a.accepted, a.total, a.tag_energy, a.scat_energy, a.det_energy, a.count);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    tag_off = -216; tag_gn = 9630; scat_off = -228; scat_gn = 11705;
    det_off = -177; det_gn = 9883; win_lo = 7520; win_hi = 8480;
    acc_cnt = '0;
    foreach (tag_h[i]) begin
      tag_h[i] = '0; det_h[i] = '0; scat_h[i] = '0; sum_h[i] = '0;
    end
    foreach (pair_h[i]) pair_h[i] = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i[4:2])
          cgh_pkg::REG_TAG_OFFSET:  tag_off  = longint'($signed(pwdata_i[14:0]));
          cgh_pkg::REG_TAG_GAIN:    tag_gn   = pwdata_i[15:0];
          cgh_pkg::REG_SCAT_OFFSET: scat_off = longint'($signed(pwdata_i[14:0]));
          cgh_pkg::REG_SCAT_GAIN:   scat_gn  = pwdata_i[15:0];
          cgh_pkg::REG_DET_OFFSET:  det_off  = longint'($signed(pwdata_i[14:0]));
          cgh_pkg::REG_DET_GAIN:    det_gn   = pwdata_i[15:0];
          cgh_pkg::REG_WIN_LOW:     win_lo   = pwdata_i[15:0];
          cgh_pkg::REG_WIN_HIGH:    win_hi   = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_item();
      if (out_valid_i && out_ready_i) compare_result();
      pending_o = expected_q.size();
    end
  end

endmodule

[sim/tb_coincidence_gate_histogrammer.sv]
// Stimulus and verdict for the coincidence gate histogrammer.
`timescale 1ns / 1ps
module tb_coincidence_gate_histogrammer;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic command_i = 1'b0;
  logic [13:0] tag_raw_i = '0, scat_raw_i = '0, det_raw_i = '0;
  logic [2:0] hist_select_i = '0;
  logic [6:0] bin_x_i = '0, bin_y_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic accepted_o;
  logic [31:0] accepted_total_o, bin_count_o;
  logic signed [22:0] tag_energy_o, scat_energy_o, det_energy_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fail_count, pending;
  int hold_off = 0;
  int rx_wait = 0;
  int rx_draw;
  bit drain_fast = 0;

  always #5 clk_i = ~clk_i;

  coincidence_gate_histogrammer dut (.*);

  cgh_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .tag_raw_i,
    .scat_raw_i, .det_raw_i, .hist_select_i, .bin_x_i, .bin_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .accepted_i(accepted_o),
    .accepted_total_i(accepted_total_o),
    .tag_energy_i(tag_energy_o), .scat_energy_i(scat_energy_o),
    .det_energy_i(det_energy_o), .bin_count_i(bin_count_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random wait per transfer, long hold-off when asked, ready while draining
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (drain_fast) begin
      rx_wait <= 0;
      out_ready_i <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      rx_draw = $urandom_range(0, 3);
      rx_wait <= rx_draw;
      out_ready_i <= (rx_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready_i <= (rx_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays high after the transfer when the next item follows at once
  task automatic send_item(logic cmd, logic [13:0] t, logic [13:0] s, logic [13:0] d,
                           logic [2:0] sel, logic [6:0] x, logic [6:0] y);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd; tag_raw_i <= t; scat_raw_i <= s; det_raw_i <= d;
    hist_select_i <= sel; bin_x_i <= x; bin_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    drain_fast = 1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    drain_fast = 0;
  endtask

  // random event, tag raw 850 to 970: above the window at reset calibration
  task automatic send_event_near();
    send_item(cgh_pkg::CMD_EVENT, 14'(850 + $urandom_range(0, 120)),
              14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383) >> $urandom_range(0, 6)), 3'd0, 7'd0, 7'd0);
  endtask

  task automatic send_read();
    send_item(cgh_pkg::CMD_READ, 14'($urandom), 14'($urandom), 14'($urandom),
              3'($urandom_range(0, 5) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4)),
              7'($urandom_range(0, 9) == 0 ?
                 $urandom_range(100, 127) : $urandom_range(0, 99)),
              7'($urandom_range(0, 9) == 0 ?
                 $urandom_range(100, 127) : $urandom_range(0, 99)));
  endtask

  task automatic random_phase(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_event_near();
        5, 6: send_item(cgh_pkg::CMD_EVENT, 14'($urandom), 14'($urandom), 14'($urandom),
                        3'($urandom), 7'($urandom), 7'($urandom));
        default: send_read();
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, reads of each histogram, bad selector and indices
    send_item(cgh_pkg::CMD_EVENT, 14'd0, 14'd0, 14'd0, 3'd0, 7'd0, 7'd0);
    send_item(cgh_pkg::CMD_EVENT, 14'h3FFF, 14'h3FFF, 14'h3FFF, 3'd7, 7'h7F, 7'h7F);
    send_item(cgh_pkg::CMD_EVENT, 14'd900, 14'd500, 14'd300, 3'd0, 7'd0, 7'd0);
    send_item(cgh_pkg::CMD_EVENT, 14'd900, 14'd500, 14'd300, 3'd0, 7'd0, 7'd0);
    send_item(cgh_pkg::CMD_EVENT, 14'd803, 14'd100, 14'd100, 3'd0, 7'd0, 7'd0);
    for (int h = 0; h < 8; h++) send_item(cgh_pkg::CMD_READ, '0, '0, '0, h[2:0], 7'd5, 7'd3);
    send_item(cgh_pkg::CMD_READ, '1, '1, '1, cgh_pkg::HIST_TAG, 7'd99, 7'd99);
    send_item(cgh_pkg::CMD_READ, '0, '0, '0, cgh_pkg::HIST_TAG, 7'd100, 7'd0);
    send_item(cgh_pkg::CMD_READ, '0, '0, '0, cgh_pkg::HIST_PAIR, 7'd0, 7'd127);
    send_item(cgh_pkg::CMD_READ, '0, '0, '0, cgh_pkg::HIST_DET, 7'h7F, 7'd0);
    wait_idle();
    // long receiver stall while the sender keeps pushing
    hold_off = 60;
    random_phase(300);
    wait_idle();
    // extremes of the calibration
    reg_write(cgh_pkg::REG_TAG_OFFSET, 32'h0000_4000);
    reg_write(cgh_pkg::REG_TAG_GAIN, 32'h0000_FFFF);
    reg_write(cgh_pkg::REG_SCAT_OFFSET, 32'h0000_3FFF);
    reg_write(cgh_pkg::REG_SCAT_GAIN, 32'h0000_0000);
    reg_write(cgh_pkg::REG_DET_OFFSET, 32'hFFFF_C000);
    reg_write(cgh_pkg::REG_DET_GAIN, 32'h0000_FFFF);
    reg_write(cgh_pkg::REG_WIN_LOW, 32'h0000_0000);
    reg_write(cgh_pkg::REG_WIN_HIGH, 32'h0000_FFFF);
    random_phase(400);
    wait_idle();
    repeat (3) begin
      reg_write(cgh_pkg::REG_TAG_OFFSET, $urandom);
      reg_write(cgh_pkg::REG_TAG_GAIN, $urandom);
      reg_write(cgh_pkg::REG_SCAT_OFFSET, $urandom);
      reg_write(cgh_pkg::REG_SCAT_GAIN, $urandom);
      reg_write(cgh_pkg::REG_DET_OFFSET, $urandom);
      reg_write(cgh_pkg::REG_DET_GAIN, $urandom);
      reg_write(cgh_pkg::REG_WIN_LOW, $urandom_range(0, 4000));
      reg_write(cgh_pkg::REG_WIN_HIGH, $urandom_range(4000, 65535));
      reg_write(cgh_pkg::REG_WIN_HIGH, 32'h0000_FFFF);
      random_phase(250);
      wait_idle();
    end
    // back to the reset calibration for well-formed coincidences
    reg_write(cgh_pkg::REG_TAG_OFFSET, 32'hFFFF_FF28);
    reg_write(cgh_pkg::REG_TAG_GAIN, 32'd9630);
    reg_write(cgh_pkg::REG_SCAT_OFFSET, 32'hFFFF_FF1C);
    reg_write(cgh_pkg::REG_SCAT_GAIN, 32'd11705);
    reg_write(cgh_pkg::REG_DET_OFFSET, 32'hFFFF_FF4F);
    reg_write(cgh_pkg::REG_DET_GAIN, 32'd9883);
    reg_write(cgh_pkg::REG_WIN_LOW, 32'd7520);
    reg_write(cgh_pkg::REG_WIN_HIGH, 32'd8480);
    random_phase(400);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[coincidence_gate_histogrammer] OK");
    end else begin
      $display("[coincidence_gate_histogrammer] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[coincidence_gate_histogrammer] ERROR");
    $finish;
  end

endmodule

[coincidence_gate_histogrammer.f]
rtl/cgh_pkg.sv
rtl/cgh_calib.sv
rtl/cgh_hist_bank.sv
rtl/coincidence_gate_histogrammer.sv
sim/cgh_checker.sv
sim/tb_coincidence_gate_histogrammer.sv
